>>> rtl/core/chained_hash_table_engine_core_assert.svh
// Assertion macros for the hash table engine core.
// Clock is clk, reset is rst_n (active low) in every module that uses them.
`ifndef CHAINED_HASH_TABLE_ENGINE_CORE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only out of reset.
`define CHTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("chte assertion failed");
// Checked at every edge, reset included.
`define CHTE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("chte reset assertion failed");
`else
`define CHTE_ASSERT(lbl, prop)
`define CHTE_ASSERT_RST(lbl, prop)
`endif

`endif

>>> rtl/core/chte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package chte_pkg;

  localparam int DEF_BUCKETS = 1024;
  localparam int DEF_SLOTS   = 1024;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int STAMP_W = 64;
  localparam int CFG_W   = 11;
  localparam int CNT_W   = 11;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;

  localparam logic [CFG_W-1:0] BC_RESET = 11'd1024;

  // operations
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // result status
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_DIV,
    CMD_HEAD_LATCH,
    CMD_NODE_STEP,
    CMD_FREE_RD,
    CMD_INS_NEW,
    CMD_UPD,
    CMD_UNLINK,
    CMD_REL,
    CMD_LOOK,
    CMD_MISS,
    CMD_FULL,
    CMD_CLEAR,
    CMD_SWEEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } chte_cmd_t;

  typedef struct packed {
    logic div_last;
    logic cur_none;
    logic key_match;
    logic free_empty;
    logic sweep_last;
  } chte_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/chained_hash_table_engine_core.sv
// Operation: insert/remove/lookup run the key-modulo unit (4 key bits/cycle), read the
//   bucket head, then walk the chain (one memory read and one compare per node) and register
//   the result; a new insert also takes a slot from the free list. Clear initializes one
//   bucket and one slot per cycle.
// Throughput: one operation at a time; the next beat is taken once the result is registered.
// Reset: synchronous, active low; afterwards an init pass over all buckets and slots runs
//   with in_ready low (config writes still taken).
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_table_engine_core import chte_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int SLOTS   = DEF_SLOTS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // operation beats
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [OP_W-1:0]         in_op,
  input  wire logic [KEY_W-1:0]        in_key,
  input  wire logic signed [VAL_W-1:0] in_value_in,
  input  wire logic [STAMP_W-1:0]      in_stamp_in,
  // result beats
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [ST_W-1:0]              out_status,
  output logic signed [VAL_W-1:0]      out_value_out,
  output logic [STAMP_W-1:0]           out_stamp_out,
  output logic [CNT_W-1:0]             out_entries_in_use,
  // bucket count register write
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_W-1:0]        cfg_bucket_count
);

  chte_cmd_t cmd;
  chte_sts_t sts;

  // the register write is always accepted
  assign cfg_ready = 1'b1;

  // sequencer: walks each insert/remove/lookup through divide, head read, chain walk, update; clear runs a sweep
  chte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table memories, modulo unit, free list, counters, result register
  chte_dp #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_key             (in_key),
    .in_value_in        (in_value_in),
    .in_stamp_in        (in_stamp_in),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_bucket_count),
    .out_status         (out_status),
    .out_value_out      (out_value_out),
    .out_stamp_out      (out_stamp_out),
    .out_entries_in_use (out_entries_in_use)
  );

endmodule
`default_nettype wire

>>> rtl/core/chte_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_table_engine_core_assert.svh"
module chte_ctrl import chte_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [OP_W-1:0] in_op,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output chte_cmd_t            cmd,
  input  wire chte_sts_t       sts
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DIV, S_HEAD, S_HLATCH, S_WALK, S_CMP,
    S_INS_CHK, S_INS_WAIT, S_INS_NEW, S_REL, S_CLR, S_RESP
  } state_t;

  state_t          state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [OP_W-1:0] op_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = CMD_NOP;
    cmd.out_load  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.op = CMD_SWEEP;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_CLEAR) begin
            cmd.op    = CMD_CLEAR;
            state_nxt = S_CLR;
          end else begin
            cmd.op    = CMD_LOAD;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.op = CMD_DIV;
        if (sts.div_last) state_nxt = S_HEAD;
      end
      S_HEAD:   state_nxt = S_HLATCH;
      S_HLATCH: begin
        cmd.op    = CMD_HEAD_LATCH;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.cur_none) begin
          if (op_r == OP_INSERT) begin
            state_nxt = S_INS_CHK;
          end else begin
            cmd.op    = CMD_MISS;
            state_nxt = S_RESP;
          end
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          case (op_r)
            OP_INSERT: begin
              cmd.op    = CMD_UPD;
              state_nxt = S_RESP;
            end
            OP_REMOVE: begin
              cmd.op    = CMD_UNLINK;
              state_nxt = S_REL;
            end
            default: begin
              cmd.op    = CMD_LOOK;
              state_nxt = S_RESP;
            end
          endcase
        end else begin
          cmd.op    = CMD_NODE_STEP;
          state_nxt = S_WALK;
        end
      end
      S_INS_CHK: begin
        if (sts.free_empty) begin
          cmd.op    = CMD_FULL;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = CMD_FREE_RD;
          state_nxt = S_INS_WAIT;
        end
      end
      S_INS_WAIT: state_nxt = S_INS_NEW;
      S_INS_NEW: begin
        cmd.op    = CMD_INS_NEW;
        state_nxt = S_RESP;
      end
      S_REL: begin
        cmd.op    = CMD_REL;
        state_nxt = S_RESP;
      end
      S_CLR: begin
        cmd.op = CMD_SWEEP;
        if (sts.sweep_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      op_r        <= OP_INSERT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_valid && in_ready) op_r <= in_op;
    end
  end

  `CHTE_ASSERT_RST(a_reset_init, !rst_n |=> (state_r == S_INIT))
  `CHTE_ASSERT(a_resp_holds, (state_r == S_RESP && out_valid_r && !out_ready) |=> (state_r == S_RESP))
  `CHTE_ASSERT(a_clear_sweeps, (in_valid && in_ready && in_op == OP_CLEAR) |=> (state_r == S_CLR))
  `CHTE_ASSERT(a_load_sets_valid, cmd.out_load |=> out_valid_r)

endmodule
`default_nettype wire

>>> rtl/core/chte_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_table_engine_core_assert.svh"
module chte_dp import chte_pkg::*; #(
  parameter int BUCKETS = DEF_BUCKETS,
  parameter int SLOTS   = DEF_SLOTS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire chte_cmd_t                 cmd,
  output chte_sts_t                      sts,
  input  wire logic [KEY_W-1:0]          in_key,
  input  wire logic signed [VAL_W-1:0]   in_value_in,
  input  wire logic [STAMP_W-1:0]        in_stamp_in,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_W-1:0]          cfg_data,
  output logic [ST_W-1:0]                out_status,
  output logic signed [VAL_W-1:0]        out_value_out,
  output logic [STAMP_W-1:0]             out_stamp_out,
  output logic [CNT_W-1:0]               out_entries_in_use
);

  localparam int LW        = $clog2(SLOTS + 1);
  localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int MAXN      = (BUCKETS > SLOTS) ? BUCKETS : SLOTS;
  localparam int SWW       = (MAXN > 1) ? $clog2(MAXN) : 1;
  localparam int DIGITS    = 4;
  localparam int DIV_STEPS = KEY_W / DIGITS;
  localparam int DCW       = $clog2(DIV_STEPS);
  localparam logic [LW-1:0] LINK_NONE = LW'(SLOTS);

  // memories
  logic [LW-1:0]      heads_mem  [BUCKETS];
  logic [LW-1:0]      links_mem  [SLOTS];
  logic [KEY_W-1:0]   keys_mem   [SLOTS];
  logic [VAL_W-1:0]   vals_mem   [SLOTS];
  logic [STAMP_W-1:0] stamps_mem [SLOTS];

  logic [CFG_W-1:0]   bc_cfg_r, bc_eff;
  logic [KEY_W-1:0]   key_r, kq_r;
  logic [VAL_W-1:0]   val_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [CFG_W-1:0]   rem_r, rem_nxt;
  logic [DCW-1:0]     div_cnt_r;
  logic [LW-1:0]      head_q_r, head_r, cur_r, prev_r, link_q_r, free_r, used_r;
  logic [KEY_W-1:0]   key_q_r;
  logic [VAL_W-1:0]   val_q_r;
  logic [STAMP_W-1:0] stamp_q_r;
  logic [SWW-1:0]     sw_r;
  logic [ST_W-1:0]    res_status_r;
  logic [VAL_W-1:0]   res_val_r;
  logic [STAMP_W-1:0] res_stamp_r;

  logic [BW-1:0] bucket;
  logic [SW-1:0] node_ra;
  logic          heads_we, links_we, keys_we, data_we;
  logic [BW-1:0] heads_wa;
  logic [LW-1:0] heads_wd, links_wd;
  logic [SW-1:0] links_wa;

  function automatic logic [CFG_W-1:0] rem_step(input logic [CFG_W-1:0] r, input logic k,
                                                input logic [CFG_W-1:0] d);
    logic [CFG_W:0] t;
    t = {r, k};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[CFG_W-1:0];
  endfunction

  // effective bucket count: zero acts as one, saturate at BUCKETS
  always_comb begin
    bc_eff = bc_cfg_r;
    if (bc_cfg_r == '0) bc_eff = CFG_W'(1);
    if (32'(bc_cfg_r) > BUCKETS) bc_eff = CFG_W'(BUCKETS);
  end

  // restoring remainder, four key bits per cycle, MSB first
  always_comb begin
    rem_nxt = rem_r;
    for (int j = 0; j < DIGITS; j++) begin
      rem_nxt = rem_step(rem_nxt, kq_r[KEY_W-1-j], bc_eff);
    end
  end

  assign bucket  = BW'(rem_r);
  assign node_ra = cur_r[SW-1:0];

  assign sts.div_last   = (div_cnt_r == DCW'(DIV_STEPS - 1));
  assign sts.cur_none   = (32'(cur_r) >= SLOTS);
  assign sts.key_match  = (key_q_r == key_r);
  assign sts.free_empty = (32'(free_r) >= SLOTS);
  assign sts.sweep_last = (sw_r == SWW'(MAXN - 1));

  // memory write port selection
  always_comb begin
    heads_we = 1'b0;
    heads_wa = bucket;
    heads_wd = cur_r;
    links_we = 1'b0;
    links_wa = node_ra;
    links_wd = free_r;
    keys_we  = 1'b0;
    data_we  = 1'b0;
    case (cmd.op)
      CMD_SWEEP: begin
        heads_we = (32'(sw_r) < BUCKETS);
        heads_wa = BW'(sw_r);
        heads_wd = LINK_NONE;
        links_we = (32'(sw_r) < SLOTS);
        links_wa = SW'(sw_r);
        links_wd = LW'(32'(sw_r) + 32'd1);
      end
      CMD_INS_NEW: begin
        keys_we  = 1'b1;
        data_we  = 1'b1;
        links_we = 1'b1;
        links_wd = head_r;
        heads_we = 1'b1;
      end
      CMD_UPD: data_we = 1'b1;
      CMD_UNLINK: begin
        if (prev_r != LINK_NONE) begin
          links_we = 1'b1;
          links_wa = prev_r[SW-1:0];
          links_wd = link_q_r;
        end else begin
          heads_we = 1'b1;
          heads_wd = link_q_r;
        end
      end
      CMD_REL: links_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (heads_we) heads_mem[heads_wa] <= heads_wd;
    head_q_r <= heads_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (links_we) links_mem[links_wa] <= links_wd;
    link_q_r <= links_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (keys_we) keys_mem[node_ra] <= key_r;
    key_q_r <= keys_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      vals_mem[node_ra]   <= val_r;
      stamps_mem[node_ra] <= stamp_r;
    end
    val_q_r   <= vals_mem[node_ra];
    stamp_q_r <= stamps_mem[node_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_cfg_r <= BC_RESET;
      sw_r     <= '0;
      free_r   <= '0;
      used_r   <= '0;
    end else begin
      if (cfg_we) bc_cfg_r <= cfg_data;
      case (cmd.op)
        CMD_CLEAR: begin
          sw_r   <= '0;
          free_r <= '0;
          used_r <= '0;
        end
        CMD_SWEEP: sw_r <= sw_r + 1'b1;
        CMD_INS_NEW: begin
          free_r <= link_q_r;
          used_r <= used_r + 1'b1;
        end
        CMD_REL: begin
          free_r <= cur_r;
          if (used_r != '0) used_r <= used_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // operands, walk pointers, results
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        key_r     <= in_key;
        val_r     <= in_value_in;
        stamp_r   <= in_stamp_in;
        kq_r      <= in_key;
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      CMD_DIV: begin
        kq_r      <= kq_r << DIGITS;
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      CMD_HEAD_LATCH: begin
        cur_r  <= head_q_r;
        head_r <= head_q_r;
        prev_r <= LINK_NONE;
      end
      CMD_NODE_STEP: begin
        prev_r <= cur_r;
        cur_r  <= link_q_r;
      end
      CMD_FREE_RD: cur_r <= free_r;
      CMD_LOOK: begin
        res_status_r <= ST_OK;
        res_val_r    <= val_q_r;
        res_stamp_r  <= stamp_q_r;
      end
      CMD_MISS: begin
        res_status_r <= ST_MISSING;
        res_val_r    <= '0;
        res_stamp_r  <= '0;
      end
      CMD_FULL: begin
        res_status_r <= ST_FULL;
        res_val_r    <= '0;
        res_stamp_r  <= '0;
      end
      CMD_CLEAR, CMD_INS_NEW, CMD_UPD, CMD_REL: begin
        res_status_r <= ST_OK;
        res_val_r    <= '0;
        res_stamp_r  <= '0;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_status         <= res_status_r;
      out_value_out      <= res_val_r;
      out_stamp_out      <= res_stamp_r;
      out_entries_in_use <= CNT_W'(used_r);
    end
  end

  `CHTE_ASSERT(a_used_bound, 32'(used_r) <= SLOTS)
  `CHTE_ASSERT(a_free_bound, 32'(free_r) <= SLOTS)
  `CHTE_ASSERT(a_ins_counts, (cmd.op == CMD_INS_NEW) |=> (used_r == $past(used_r) + 1'b1))
  `CHTE_ASSERT(a_ins_has_slot, (cmd.op == CMD_INS_NEW) |-> !sts.free_empty)

endmodule
`default_nettype wire
